@@ rtl/core/cbts_pkg.sv @@
// shared types and constants for the can bit timing search block
// no dependencies
`default_nettype none

package cbts_pkg;

   localparam int BIT_RATE_W = 20;
   localparam int CLOCK_W    = 32;
   localparam int PRESC_W    = 4;
   localparam int TIMING_W   = 15;
   localparam int REST_W     = 4;
   localparam int DIV_CNT_W  = 5;

   localparam logic [CLOCK_W-1:0]   CLOCK_RATE_RESET = 32'd48000000;
   localparam logic [REST_W-1:0]    REST_LAST        = 4'd14;
   localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST     = 5'd31;
   localparam logic [1:0]           SJW_MAX          = 2'd3;

   typedef struct packed {
      logic start;
      logic div_step;
      logic srch_init;
      logic srch_step;
      logic load_out;
      logic hit;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic last;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/cbts_ctrl.sv @@
// sequencer for the bit timing search: divide, search, hand off result
// depends on cbts_pkg
`default_nettype none

module cbts_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire cbts_pkg::status_type status,
   output cbts_pkg::cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_SEARCH = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [cbts_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           hit_ff, hit_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.hit      = hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               cnt_in    = '0;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == cbts_pkg::DIV_CNT_LAST) begin
               cmd.srch_init = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.match) begin
               hit_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (status.last) begin
               hit_in   = 1'b0;
               state_in = ST_FINISH;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/cbts_dp.sv @@
// datapath: clock rate register, restoring divider, search counters, result word
// depends on cbts_pkg
`default_nettype none

module cbts_dp #(
   parameter int MAX_DIVIDER = 15,
   parameter int MAX_QUANTA  = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [cbts_pkg::CLOCK_W-1:0]    csr_write_data,
   input  wire logic [cbts_pkg::BIT_RATE_W-1:0] req_bit_rate,
   input  wire cbts_pkg::cmd_type               cmd,
   output cbts_pkg::status_type                 status,
   output logic [cbts_pkg::PRESC_W-1:0]         rsp_prescaler,
   output logic [cbts_pkg::TIMING_W-1:0]        rsp_timing_word,
   output logic                                 rsp_found
);

   localparam int D1_W = $clog2(MAX_DIVIDER + 2);
   localparam int QW   = $clog2(MAX_QUANTA + 1);
   localparam int BW   = D1_W + QW;
   localparam int PW   = BW + 5;
   localparam int CW   = cbts_pkg::CLOCK_W;
   localparam int RW   = cbts_pkg::BIT_RATE_W;

   localparam logic [D1_W-1:0] D1_LAST = D1_W'(MAX_DIVIDER + 1);
   localparam logic [QW-1:0]   QM_LAST = QW'(MAX_QUANTA - 1);

   logic [CW-1:0] clock_rate_ff;
   logic [CW-1:0] quo_ff, quo_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] divisor_ff;
   logic          zero_ff;

   logic [D1_W-1:0]                 d1_ff, d1_in;
   logic [QW-1:0]                   qm_ff, qm_in;
   logic [cbts_pkg::REST_W-1:0]     rest_ff, rest_in;
   logic [BW-1:0]                   base_ff, base_in;
   logic [PW-1:0]                   prod_ff, prod_in;

   logic [RW+1:0] diff;
   logic [RW:0]   shifted;
   logic [D1_W-1:0] d1_next;
   logic [BW-1:0]   base_next;

   logic [2:0] seg1;
   logic [2:0] seg2;
   logic [1:0] sjw;

   logic [cbts_pkg::PRESC_W-1:0]  presc_ff;
   logic [cbts_pkg::TIMING_W-1:0] timing_ff;
   logic                          found_ff;

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_rate_ff <= cbts_pkg::CLOCK_RATE_RESET;
      end else if (csr_write_enable) begin
         clock_rate_ff <= csr_write_data;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[CW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.start) begin
         quo_in = clock_rate_ff;
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (!diff[RW+1]) begin
            rem_in = diff[RW-1:0];
            quo_in = {quo_ff[CW-2:0], 1'b1};
         end else begin
            rem_in = shifted[RW-1:0];
            quo_in = {quo_ff[CW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.start) begin
         divisor_ff <= req_bit_rate;
         zero_ff    <= (req_bit_rate == '0);
      end
   end

   // search counters, product kept as running sum
   assign d1_next   = d1_ff + 1'b1;
   assign base_next = base_ff + BW'(d1_ff);

   always_comb begin
      d1_in   = d1_ff;
      qm_in   = qm_ff;
      rest_in = rest_ff;
      base_in = base_ff;
      prod_in = prod_ff;
      if (cmd.srch_init) begin
         d1_in   = D1_W'(1);
         qm_in   = '0;
         rest_in = '0;
         base_in = BW'(1);
         prod_in = PW'(3);
      end else if (cmd.srch_step) begin
         if (rest_ff != cbts_pkg::REST_LAST) begin
            rest_in = rest_ff + 1'b1;
            prod_in = prod_ff + PW'(base_ff);
         end else if (qm_ff != QM_LAST) begin
            rest_in = '0;
            qm_in   = qm_ff + 1'b1;
            base_in = base_next;
            prod_in = PW'(base_next) + PW'({base_next, 1'b0});
         end else begin
            rest_in = '0;
            qm_in   = '0;
            d1_in   = d1_next;
            base_in = BW'(d1_next);
            prod_in = PW'(d1_next) + PW'({d1_next, 1'b0});
         end
      end
   end

   always_ff @(posedge clock) begin
      d1_ff   <= d1_in;
      qm_ff   <= qm_in;
      rest_ff <= rest_in;
      base_ff <= base_in;
      prod_ff <= prod_in;
   end

   assign status.match = !zero_ff && (CW'(prod_ff) == quo_ff);
   assign status.last  = (d1_ff == D1_LAST) && (qm_ff == QM_LAST)
                         && (rest_ff == cbts_pkg::REST_LAST);

   // result word
   assign seg1 = rest_ff[3:1];
   assign seg2 = 3'(rest_ff - {1'b0, seg1});
   assign sjw  = (seg1 > 3'(cbts_pkg::SJW_MAX)) ? cbts_pkg::SJW_MAX : seg1[1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (cmd.hit) begin
            presc_ff  <= cbts_pkg::PRESC_W'(d1_ff - 1'b1);
            timing_ff <= {seg2, 1'b0, seg1, sjw, 6'(qm_ff)};
            found_ff  <= 1'b1;
         end else begin
            presc_ff  <= '0;
            timing_ff <= '0;
            found_ff  <= 1'b0;
         end
      end
   end

   assign rsp_prescaler   = presc_ff;
   assign rsp_timing_word = timing_ff;
   assign rsp_found       = found_ff;

endmodule

`default_nettype wire

@@ rtl/core/can_bit_timing_search.sv @@
// top level of the can bit timing search: sequencer plus datapath
// depends on cbts_pkg, cbts_ctrl, cbts_dp
//
//   port group   dir   handshake             payload
//   req_         in    req_valid/req_ready   req_bit_rate
//   rsp_         out   rsp_valid/rsp_ready   rsp_prescaler, rsp_timing_word, rsp_found
//   csr_         in    csr_write_enable      csr_write_data (clock rate)
//
// one word at a time: the word is accepted, the restoring divider forms the quotient bit by bit,
// then one search step per cycle over up to (MAX_DIVIDER+1)*MAX_QUANTA*15
// combinations, and the result is loaded into the output register. the output
// register holds a result until taken, so the next word is accepted while the
// result still waits. reset is synchronous, active high.
`default_nettype none

module can_bit_timing_search #(
   parameter int MAX_DIVIDER = 15,
   parameter int MAX_QUANTA  = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [cbts_pkg::CLOCK_W-1:0]    csr_write_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [cbts_pkg::BIT_RATE_W-1:0] req_bit_rate,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [cbts_pkg::PRESC_W-1:0]         rsp_prescaler,
   output logic [cbts_pkg::TIMING_W-1:0]        rsp_timing_word,
   output logic                                 rsp_found
);

   cbts_pkg::cmd_type    cmd;
   cbts_pkg::status_type status;

   cbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cbts_dp #(
      .MAX_DIVIDER (MAX_DIVIDER),
      .MAX_QUANTA  (MAX_QUANTA)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bit_rate     (req_bit_rate),
      .cmd              (cmd),
      .status           (status),
      .rsp_prescaler    (rsp_prescaler),
      .rsp_timing_word  (rsp_timing_word),
      .rsp_found        (rsp_found)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block still ready after taking a word");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_prescaler == '0 && rsp_timing_word == '0)
      else $error("no-match result carries nonzero fields");

   a_sjw_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found && rsp_timing_word[11:8] >= 4'd3 |->
         rsp_timing_word[7:6] == 2'd3)
      else $error("sync jump width not capped at three");

   a_one_step_kind: assert property (@(posedge clock) disable iff (reset)
      !(cmd.div_step && cmd.srch_step) && !(cmd.start && cmd.load_out))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

@@ test/tb_can_bit_timing_search.sv @@
`timescale 1ns / 1ps
// testbench for can_bit_timing_search: directed and random bit rates under several clock rates
// each response word is checked against a local model of the timing search
// depends on cbts_pkg and can_bit_timing_search

module tb_can_bit_timing_search;

   localparam int MAX_DIVIDER = 15;
   localparam int MAX_QUANTA = 32;
   localparam int SEGS_FIRST = 3;
   localparam int SEGS_LAST = 17;
   localparam int SJW_CAP = 3;
   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_WORDS = 16;
   localparam longint CYCLE_LIMIT = 6_000_000;
   localparam logic [cbts_pkg::BIT_RATE_W-1:0] RATE_MAX = {cbts_pkg::BIT_RATE_W{1'b1}};
   localparam logic [cbts_pkg::CLOCK_W-1:0] CLOCK_MAX = {cbts_pkg::CLOCK_W{1'b1}};

   typedef struct packed {
      logic [cbts_pkg::PRESC_W-1:0] prescaler;
      logic [cbts_pkg::TIMING_W-1:0] timing_word;
      logic found;
   } timing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [cbts_pkg::CLOCK_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [cbts_pkg::BIT_RATE_W-1:0] req_bit_rate = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [cbts_pkg::PRESC_W-1:0] rsp_prescaler;
   logic [cbts_pkg::TIMING_W-1:0] rsp_timing_word;
   logic rsp_found;

   timing_type pending_timings[$];
   logic [cbts_pkg::CLOCK_W-1:0] cur_clock_rate = cbts_pkg::CLOCK_RATE_RESET;
   logic burst_mode = 1'b0;
   int ready_hold = 0;
   int fail_count = 0;
   longint cycle_count = 0;

   can_bit_timing_search #(
      .MAX_DIVIDER(MAX_DIVIDER),
      .MAX_QUANTA(MAX_QUANTA)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_bit_rate(req_bit_rate),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_prescaler(rsp_prescaler),
      .rsp_timing_word(rsp_timing_word),
      .rsp_found(rsp_found)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic timing_type search_timing(logic [cbts_pkg::CLOCK_W-1:0] clk_hz,
                                                logic [cbts_pkg::BIT_RATE_W-1:0] rate);
      timing_type t;
      longint unsigned per_bit;
      int unsigned seg1;
      int unsigned seg2;
      int unsigned sjw;
      int unsigned quanta_m1;
      t = '0;
      if (rate == '0) return t;
      per_bit = clk_hz / rate;
      for (int unsigned d = 0; d <= MAX_DIVIDER; d++) begin
         for (int unsigned q = 1; q <= MAX_QUANTA; q++) begin
            for (int unsigned s = SEGS_FIRST; s <= SEGS_LAST; s++) begin
               if (per_bit == s * q * (d + 1)) begin
                  seg1 = (s - SEGS_FIRST) / 2;
                  seg2 = s - SEGS_FIRST - seg1;
                  sjw = (seg1 > SJW_CAP) ? SJW_CAP : seg1;
                  quanta_m1 = q - 1;
                  t.prescaler = d[cbts_pkg::PRESC_W-1:0];
                  t.timing_word = {seg2[2:0], seg1[3:0], sjw[1:0], quanta_m1[5:0]};
                  t.found = 1'b1;
                  return t;
               end
            end
         end
      end
      return t;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // mostly rates that divide into an exact product, some near misses and raw noise
   function automatic logic [cbts_pkg::BIT_RATE_W-1:0] random_rate();
      logic [31:0] raw;
      int unsigned per_bit;
      logic [cbts_pkg::CLOCK_W-1:0] rate;
      raw = $urandom;
      if ($urandom_range(0, 3) == 0) return raw[cbts_pkg::BIT_RATE_W-1:0];
      per_bit = $urandom_range(SEGS_FIRST, SEGS_LAST) * $urandom_range(1, MAX_QUANTA)
                * $urandom_range(1, MAX_DIVIDER + 1);
      rate = cur_clock_rate / per_bit;
      if ($urandom_range(0, 7) == 0) rate = rate + 1;
      if (rate == '0 || rate > RATE_MAX) return raw[cbts_pkg::BIT_RATE_W-1:0];
      return rate[cbts_pkg::BIT_RATE_W-1:0];
   endfunction

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic send_bit_rate(logic [cbts_pkg::BIT_RATE_W-1:0] rate);
      int gap;
      gap = burst_mode ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_bit_rate <= rate;
      do @(posedge clock); while (!req_ready);
      pending_timings.push_back(search_timing(cur_clock_rate, rate));
   endtask

   task automatic wait_idle(int cycles);
      req_valid <= 1'b0;
      while (pending_timings.size() != 0) @(posedge clock);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic set_clock_rate(logic [cbts_pkg::CLOCK_W-1:0] hz);
      wait_idle(SETTLE_CYCLES);
      csr_write_enable <= 1'b1;
      csr_write_data <= hz;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_clock_rate = hz;
   endtask

   task automatic test_reset_clock();
      send_bit_rate(20'd1000000);
      send_bit_rate(20'd500000);
      send_bit_rate(20'd125000);
      send_bit_rate(RATE_MAX);
      send_bit_rate(20'd1);
      send_bit_rate(20'd0);
   endtask

   task automatic test_zero_clock();
      set_clock_rate('0);
      send_bit_rate(20'd1);
      send_bit_rate(20'd1000000);
      send_bit_rate(RATE_MAX);
      send_bit_rate(20'd0);
      set_clock_rate(32'd1);
      send_bit_rate(20'd1);
   endtask

   task automatic test_max_clock();
      set_clock_rate(CLOCK_MAX);
      send_bit_rate(RATE_MAX);
      send_bit_rate(20'd1);
      send_bit_rate(20'h80000);
   endtask

   task automatic test_timing_extremes();
      // largest product, every timing field at its top
      set_clock_rate(32'd8704000);
      send_bit_rate(20'd1000);
      // smallest product, all timing fields zero but found
      set_clock_rate(32'd3000000);
      send_bit_rate(20'd1000000);
      set_clock_rate(32'd20);
      send_bit_rate(20'd1);
   endtask

   task automatic test_paused_sends();
      set_clock_rate(cbts_pkg::CLOCK_RATE_RESET);
      send_bit_rate(20'd250000);
      wait_idle(0);
      send_bit_rate(20'd1000000);
      wait_idle(0);
      send_bit_rate(20'd33);
   endtask

   task automatic test_random_rates();
      logic [cbts_pkg::CLOCK_W-1:0] phase_clock;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: phase_clock = 32'd48000000;
            1: phase_clock = 32'd40000000;
            2: phase_clock = 32'd16000000;
            3: phase_clock = 32'd80000000;
            default: phase_clock = $urandom;
         endcase
         set_clock_rate(phase_clock);
         burst_mode <= (phase == 2);
         repeat (PHASE_WORDS) send_bit_rate(random_rate());
      end
      burst_mode <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (burst_mode) begin
         rsp_ready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready <= !rsp_ready;
         ready_hold <= rsp_ready ? idle_gap() : $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin : response_check
      timing_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_timings.size() == 0) begin
            $display("%0t: unexpected word, expected none, got prescaler %0d timing %0h %s %0b",
                     $time, rsp_prescaler, rsp_timing_word, "found", rsp_found);
            fail_count++;
         end else begin
            want = pending_timings.pop_front();
            compare_field("prescaler", want.prescaler, rsp_prescaler);
            compare_field("timing_word", want.timing_word, rsp_timing_word);
            compare_field("found", want.found, rsp_found);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout", $time);
      $display("tb_can_bit_timing_search: FAIL");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_clock();
      test_zero_clock();
      test_max_clock();
      test_timing_extremes();
      test_paused_sends();
      test_random_rates();
      wait_idle(DRAIN_CYCLES);
      if (fail_count == 0) begin
         $display("tb_can_bit_timing_search: PASS");
      end else begin
         $display("tb_can_bit_timing_search: FAIL");
      end
      $finish;
   end

endmodule
